// ----- sv/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants for the range max segment tree
// Default sizes, operation codes, and the command/status bundles passed
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // one command per cycle at most
    typedef struct packed {
        logic load;      // capture the accepted item
        logic clr_step;  // zero one node of the clearing pass
        logic upd_leaf;  // write the leaf, read its sibling
        logic upd_up;    // write a parent, read the parent's sibling
        logic q_lo;      // fold the high-side data, step the low bound
        logic q_hi;      // fold the low-side data, step the high bound, go up
        logic out_load;  // move the accumulator to the result register
    } rmst_cmd_t;

    typedef struct packed {
        logic clr_last;    // clearing pass is at its last node
        logic leaf_ok;     // update leaf lies inside the tree
        logic range_empty; // query range holds no leaf
        logic at_top;      // parent of the current node is the root
        logic lo_lt_hi;    // query walk still has nodes to cover
    } rmst_sts_t;

endpackage

// ----- sv/rmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmst_ctrl: sequencing state machine for the range max segment tree
// Runs the clearing pass, walks updates leaf to root and queries bottom-up,
// and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module rmst_ctrl
    import rmst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  logic      operation,
    output logic      result_valid,
    input  logic      result_ready,
    input  rmst_sts_t sts,
    output rmst_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ULEAF = 3'd2;
    localparam logic [2:0] S_UUP   = 3'd3;
    localparam logic [2:0] S_QLO   = 3'd4;
    localparam logic [2:0] S_QHI   = 3'd5;
    localparam logic [2:0] S_QDONE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       accept;
    logic       out_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign out_free     = !valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (operation == OP_QUERY)
                        state_next = sts.range_empty ? S_QDONE : S_QLO;
                    else if (sts.leaf_ok)
                        state_next = S_ULEAF;
                end
            end
            S_ULEAF:
            begin
                cmd.upd_leaf = 1'b1;
                state_next   = S_UUP;
            end
            S_UUP:
            begin
                cmd.upd_up = 1'b1;
                if (sts.at_top)
                    state_next = S_IDLE;
            end
            S_QLO:
            begin
                cmd.q_lo   = 1'b1;
                state_next = sts.lo_lt_hi ? S_QHI : S_QDONE;
            end
            S_QHI:
            begin
                cmd.q_hi   = 1'b1;
                state_next = S_QLO;
            end
            S_QDONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- sv/rmst_datapath.sv -----
// ----------------------------------------------------------------------------
// rmst_datapath: node memory and walk registers for the range max tree
// Node i has children 2i and 2i+1, leaf j sits at node LEAVES + j.
// One write and one registered read of the node memory per cycle.
// ----------------------------------------------------------------------------
module rmst_datapath
    import rmst_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [9:0]  leaf_index,
    input  logic [31:0] new_value,
    input  logic [10:0] range_low,
    input  logic [10:0] range_high,
    output logic [31:0] max_value,
    input  rmst_cmd_t   cmd,
    output rmst_sts_t   sts
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int PW    = $clog2(NODES + 1);

    logic [VALUE_BITS-1:0] mem [NODES];
    logic [VALUE_BITS-1:0] rdata_reg;

    logic [AW-1:0]         clr_reg, clr_next;
    logic                  lo_pend_reg, lo_pend_next;
    logic                  hi_pend_reg, hi_pend_next;
    logic [PW-1:0]         lo_reg, lo_next;
    logic [PW-1:0]         hi_reg, hi_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [VALUE_BITS-1:0] carry_reg, carry_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [31:0]           max_value_reg, max_value_next;

    logic [31:0]           lo_ext, hi_ext, hi_sat;
    logic [AW-1:0]         parent;
    logic [PW-1:0]         hi_dec;
    logic [VALUE_BITS-1:0] up_max;
    logic [VALUE_BITS-1:0] fold_in;
    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wdata;

    // item decode
    assign lo_ext = 32'(range_low);
    assign hi_ext = 32'(range_high);
    assign hi_sat = (hi_ext > 32'(LEAVES)) ? 32'(LEAVES) : hi_ext;

    assign parent = node_reg >> 1;
    assign hi_dec = hi_reg - PW'(1);
    assign up_max = (rdata_reg > carry_reg) ? rdata_reg : carry_reg;

    assign sts.clr_last    = (clr_reg == AW'(NODES - 1));
    assign sts.leaf_ok     = (32'(leaf_index) < 32'(LEAVES));
    assign sts.range_empty = (lo_ext >= hi_sat);
    assign sts.at_top      = (parent == AW'(1));
    assign sts.lo_lt_hi    = (lo_reg < hi_reg);

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = clr_reg;
        raddr = lo_reg[AW-1:0];
        wdata = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        if (cmd.upd_leaf)
        begin
            we    = 1'b1;
            waddr = node_reg;
            wdata = carry_reg;
            re    = 1'b1;
            raddr = node_reg ^ AW'(1);
        end
        if (cmd.upd_up)
        begin
            we    = 1'b1;
            waddr = parent;
            wdata = up_max;
            re    = 1'b1;
            raddr = parent ^ AW'(1);
        end
        if (cmd.q_lo)
        begin
            re    = sts.lo_lt_hi && lo_reg[0];
            raddr = lo_reg[AW-1:0];
        end
        if (cmd.q_hi)
        begin
            re    = hi_reg[0];
            raddr = hi_dec[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // data from a read issued in the previous step, zero if none was issued
    always_comb
    begin
        fold_in = '0;
        if (cmd.q_lo && hi_pend_reg)
            fold_in = rdata_reg;
        if (cmd.q_hi && lo_pend_reg)
            fold_in = rdata_reg;
    end

    always_comb
    begin
        clr_next       = clr_reg;
        lo_pend_next   = lo_pend_reg;
        hi_pend_next   = hi_pend_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        node_next      = node_reg;
        carry_next     = carry_reg;
        acc_next       = acc_reg;
        max_value_next = max_value_reg;

        if (cmd.clr_step)
            clr_next = clr_reg + AW'(1);

        if (cmd.load)
        begin
            lo_next      = PW'(lo_ext + 32'(LEAVES));
            hi_next      = PW'(hi_sat + 32'(LEAVES));
            node_next    = AW'(32'(leaf_index) + 32'(LEAVES));
            carry_next   = VALUE_BITS'(new_value);
            acc_next     = '0;
            lo_pend_next = 1'b0;
            hi_pend_next = 1'b0;
        end

        if (cmd.upd_up)
        begin
            node_next  = parent;
            carry_next = up_max;
        end

        if (cmd.q_lo)
        begin
            acc_next     = (fold_in > acc_reg) ? fold_in : acc_reg;
            hi_pend_next = 1'b0;
            lo_pend_next = sts.lo_lt_hi && lo_reg[0];
            if (sts.lo_lt_hi && lo_reg[0])
                lo_next = lo_reg + PW'(1);
        end

        if (cmd.q_hi)
        begin
            acc_next     = (fold_in > acc_reg) ? fold_in : acc_reg;
            lo_pend_next = 1'b0;
            hi_pend_next = hi_reg[0];
            lo_next      = lo_reg >> 1;
            hi_next      = (hi_reg[0] ? hi_dec : hi_reg) >> 1;
        end

        if (cmd.out_load)
            max_value_next = 32'(acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            lo_pend_reg <= 1'b0;
            hi_pend_reg <= 1'b0;
        end
        else
        begin
            clr_reg     <= clr_next;
            lo_pend_reg <= lo_pend_next;
            hi_pend_reg <= hi_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        node_reg      <= node_next;
        carry_reg     <= carry_next;
        acc_reg       <= acc_next;
        max_value_reg <= max_value_next;
    end

    assign max_value = max_value_reg;

endmodule

// ----- sv/range_max_segment_tree.sv -----
// ----------------------------------------------------------------------------
// range_max_segment_tree: max segment tree with leaf update and range query
// Channels:
//   channel  handshake                  payload
//   item     item_valid / item_ready    operation, leaf_index, new_value,
//                                       range_low, range_high
//   result   result_valid / result_ready max_value (one per query)
// Update: walks from the leaf to the root, one tree level per cycle, writing
// each node and reading its sibling for the level above.
// Query: walks bottom-up in a low step and a high step per tree level;
// each level needs up to two reads of the one memory read port.
// After reset a clearing pass zeroes all 2*LEAVES nodes, one per cycle;
// item_ready stays low until it ends.
// A finished query waits while an earlier result has not been taken.
// ----------------------------------------------------------------------------
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        operation,
    input  logic [9:0]  leaf_index,
    input  logic [31:0] new_value,
    input  logic [10:0] range_low,
    input  logic [10:0] range_high,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] max_value
);

    rmst_cmd_t cmd;
    rmst_sts_t sts;

    rmst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    rmst_datapath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_index (leaf_index),
        .new_value  (new_value),
        .range_low  (range_low),
        .range_high (range_high),
        .max_value  (max_value),
        .cmd        (cmd),
        .sts        (sts)
    );

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clr_step, cmd.upd_leaf, cmd.upd_up,
                  cmd.q_lo, cmd.q_hi, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid || result_ready))
        else $error("result register loaded while holding an untaken result");

    a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && operation == OP_UPDATE) |=> !cmd.out_load)
        else $error("update produced a result");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !item_ready)
        else $error("item accepted during clearing pass");

endmodule

// ----- verif/range_max_segment_tree_test.sv -----
// ----------------------------------------------------------------------------
// range_max_segment_tree_test: self-checking bench for the max segment tree
// Drives leaf updates and range max queries over valid/ready, keeps its own
// copy of the tree to predict every query result, and compares each result
// transfer in order. Covers bound saturation, empty ranges, idle mixes on
// both channels, a long result stall and a full drain between bursts.
// ----------------------------------------------------------------------------
module range_max_segment_tree_test;
    import rmst_pkg::*;

    localparam int LEAVES         = LEAVES_DEF;
    localparam int NODES          = 2 * LEAVES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 48;
    localparam int HOLD_CYCLES    = 400;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    logic        operation    = OP_UPDATE;
    logic [9:0]  leaf_index   = '0;
    logic [31:0] new_value    = '0;
    logic [10:0] range_low    = '0;
    logic [10:0] range_high   = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] max_value;

    // shadow copy of the tree, same bottom-up layout as the block
    logic [31:0] tree_mem [0:NODES-1];
    logic [31:0] max_expected [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic recv_holding = 1'b0;
    event long_hold_ev;

    int  mismatches   = 0;
    int  n_updates    = 0;
    int  n_queries    = 0;
    int  n_checked    = 0;
    int  n_nonzero    = 0;
    int  stall_cycles = 0;

    range_max_segment_tree u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .leaf_index   (leaf_index),
        .new_value    (new_value),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .max_value    (max_value)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // tree predictor
    // ------------------------------------------------------------------
    function automatic void tree_set_leaf(input logic [9:0] leaf, input logic [31:0] val);
        int unsigned node;
        if (leaf >= LEAVES)
            return;
        node = LEAVES + leaf;
        tree_mem[node] = val;
        node = node >> 1;
        while (node != 0) begin
            tree_mem[node] = (tree_mem[2*node] > tree_mem[2*node+1]) ?
                             tree_mem[2*node] : tree_mem[2*node+1];
            node = node >> 1;
        end
    endfunction

    function automatic logic [31:0] tree_range_max(input logic [10:0] lo_in,
                                                   input logic [10:0] hi_in);
        int unsigned lo;
        int unsigned hi;
        logic [31:0] best;
        lo   = lo_in;
        hi   = hi_in;
        best = '0;
        if (hi > LEAVES)
            hi = LEAVES;
        if (lo >= hi)
            return '0;
        lo += LEAVES;
        hi += LEAVES;
        while (lo < hi) begin
            if ((lo & 1) != 0) begin
                if (tree_mem[lo] > best)
                    best = tree_mem[lo];
                lo++;
            end
            if ((hi & 1) != 0) begin
                hi--;
                if (tree_mem[hi] > best)
                    best = tree_mem[hi];
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return best;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, plus a long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (recv_holding)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        forever
        begin
            @(long_hold_ev);
            @(posedge clk);
            recv_holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            recv_holding <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // transfer monitor: predict on item transfer, check on result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                if (operation == OP_UPDATE)
                begin
                    tree_set_leaf(leaf_index, new_value);
                    n_updates++;
                end
                else
                begin
                    max_expected.push_back(tree_range_max(range_low, range_high));
                    n_queries++;
                end
            end
            if (result_valid && result_ready)
            begin
                if (max_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual max_value %0h",
                             $time, max_value);
                end
                else
                begin
                    want = max_expected.pop_front();
                    n_checked++;
                    if (want != 0)
                        n_nonzero++;
                    if (max_value !== want)
                    begin
                        mismatches++;
                        $display("%0t: max_value mismatch, expected %0h, actual %0h",
                                 $time, want, max_value);
                    end
                end
            end
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, max_expected.size());
                $display("** range_max_segment_tree: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [9:0] leaf, input logic [31:0] val,
                             input logic [10:0] lo, input logic [10:0] hi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        leaf_index <= leaf;
        new_value  <= val;
        range_low  <= lo;
        range_high <= hi;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // unused fields carry noise so the block must ignore them
    task automatic put_leaf(input logic [9:0] leaf, input logic [31:0] val);
        send_item(OP_UPDATE, leaf, val, 11'($urandom), 11'($urandom));
    endtask

    task automatic ask_range(input logic [10:0] lo, input logic [10:0] hi);
        send_item(OP_QUERY, 10'($urandom), $urandom, lo, hi);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            2, 3:    return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        logic [10:0] lo;
        logic [10:0] hi;
        logic [9:0]  leaf;
        if ($urandom_range(1) == 0)
        begin
            // a quarter of updates land in a hot window that queries revisit
            leaf = ($urandom_range(3) == 0) ? 10'($urandom_range(31)) : 10'($urandom);
            put_leaf(leaf, pick_value());
        end
        else
        begin
            lo = 11'($urandom_range(LEAVES - 1));
            case ($urandom_range(9))
                0:       begin lo = 11'($urandom); hi = 11'($urandom); end
                1:       hi = 11'($urandom_range(LEAVES, 2047));
                2:       hi = lo;
                3:       begin lo = 11'($urandom_range(LEAVES, 2047)); hi = 11'($urandom); end
                4:       begin lo = 11'($urandom_range(31)); hi = 11'($urandom_range(32)); end
                5:       begin lo = '0; hi = 11'(LEAVES); end
                6, 7:    hi = 11'($urandom_range(lo + 1, lo + 16 > LEAVES ? LEAVES : lo + 16));
                default: hi = 11'($urandom_range(lo + 1, LEAVES));
            endcase
            ask_range(lo, hi);
        end
    endtask

    // drop item_valid and let the monitor log the last transfer before checking
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (max_expected.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ask_range(11'd0, 11'(LEAVES));          // empty tree
        put_leaf(10'd0, 32'hFFFF_FFFF);
        put_leaf(10'(LEAVES - 1), 32'd1);
        ask_range(11'd0, 11'd1);
        ask_range(11'd1, 11'(LEAVES));
        ask_range(11'(LEAVES - 1), 11'd2047);   // high bound saturates
        ask_range(11'd0, 11'd2047);
        ask_range(11'd5, 11'd5);                // empty range
        ask_range(11'd10, 11'd3);               // low above high
        ask_range(11'(LEAVES), 11'(LEAVES));    // low at the end of the tree
        ask_range(11'd2047, 11'd2047);
        ask_range(11'd2047, 11'd0);
        ask_range(11'd0, 11'd0);
        put_leaf(10'd0, 32'd0);                 // the max drops back
        ask_range(11'd0, 11'(LEAVES));
        put_leaf(10'd512, 32'h8000_0000);
        put_leaf(10'd511, 32'h7FFF_FFFF);
        ask_range(11'd511, 11'd513);
        ask_range(11'd0, 11'd512);
        ask_range(11'd513, 11'(LEAVES));
        put_leaf(10'(LEAVES - 1), 32'd0);
        ask_range(11'd512, 11'(LEAVES - 1));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n_items) send_random_item();
    endtask

    // result side stops for a long stretch while items keep coming
    task automatic test_result_stall();
        send_idle_pct = 0;
        -> long_hold_ev;
        repeat (40) send_random_item();
        wait_drained();
    endtask

    // bursts separated by a full drain of outstanding results
    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat (20) send_random_item();
            wait_drained();
        end
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
            tree_mem[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(540, 8, 80);
        test_result_stall();
        test_random_traffic(540, 80, 8);
        test_drain_pause();
        test_random_traffic(540, 0, 0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (max_expected.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, max_expected.size());
        end

        $display("Covered %0d leaf updates and %0d range queries, %0d results checked",
                 n_updates, n_queries, n_checked);
        $display("(%0d non-zero), under three idle mixes, a long result stall and drains",
                 n_nonzero);
        if (mismatches == 0)
            $display("** range_max_segment_tree: PASSED **");
        else
            $display("** range_max_segment_tree: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
sv/rmst_pkg.sv
sv/rmst_ctrl.sv
sv/rmst_datapath.sv
sv/range_max_segment_tree.sv
verif/range_max_segment_tree_test.sv
